// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants of the integer to ASCII formatter
// Holds the transaction structs, command codes, controller states, the
// controller/datapath interface structs and the digit to character mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned CHAR_W  = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_UDEC  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SDEC  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIXED = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HEXB  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEXW  = 3'd4;

  // characters
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // reciprocal of ten, exact for every 16-bit dividend with a shift of 19
  localparam logic [NUM_W-1:0] RECIP_TEN = 16'd52429;
  localparam int unsigned      RECIP_SH  = 19;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [NUM_W-1:0] number;
    logic [CNT_W-1:0] digit_count;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic push_sign;
    logic pop;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic no_text;     // the offered transaction produces no characters
    logic step_final;  // the digit produced this cycle is the last one
    logic signed_mode; // the held transaction needs a sign slot
    logic pop_final;   // one character left on the stack
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else begin
      c = CHAR_UPPER + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== rtl/itoa_dpath.sv =====
// ----------------------------------------------------------------------------
// itoa_dpath: digit datapath of the integer to ASCII formatter
// Holds the working value, produces one digit per step into a character
// stack (least significant first) and pops characters most significant first.
// ----------------------------------------------------------------------------
module itoa_dpath #(
  parameter int unsigned MAX_WIDTH = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itoa_pkg::in_t        item_i,
  input  itoa_pkg::dp_cmd_t    cmd_i,
  output itoa_pkg::dp_status_t status_o,
  output logic                 strobe_o,
  output itoa_pkg::out_t       result_o
);

  localparam int unsigned DEPTH = (MAX_WIDTH > 6) ? MAX_WIDTH : 6;
  localparam int unsigned FW    = $clog2(DEPTH + 1);

  logic [itoa_pkg::CMD_W-1:0]  mode_q;
  logic [itoa_pkg::NUM_W-1:0]  val_q, val_d;
  logic [itoa_pkg::CNT_W-1:0]  left_q, left_d;
  logic                        neg_q;
  logic [itoa_pkg::CHAR_W-1:0] stack_q [DEPTH];
  logic [FW-1:0]               fill_q;
  logic                        strobe_q;
  itoa_pkg::out_t              result_q;

  // load decode
  logic                       in_neg;
  logic [itoa_pkg::CNT_W-1:0] in_cnt;
  logic [itoa_pkg::NUM_W-1:0] in_val;

  always_comb begin
    in_neg = (item_i.cmd == itoa_pkg::CMD_SDEC) && item_i.number[itoa_pkg::NUM_W-1];
    in_cnt = (item_i.digit_count > itoa_pkg::CNT_W'(MAX_WIDTH))
           ? itoa_pkg::CNT_W'(MAX_WIDTH) : item_i.digit_count;
    if (in_neg) begin
      in_val = '0 - item_i.number;
    end else if (item_i.cmd == itoa_pkg::CMD_FIXED || item_i.cmd == itoa_pkg::CMD_HEXB) begin
      in_val = {8'b0, item_i.number[7:0]};
    end else begin
      in_val = item_i.number;
    end
  end

  // one digit step: divide by ten via reciprocal, or by sixteen via shift
  logic                       hex_mode;
  logic [31:0]                prod;
  logic [itoa_pkg::NUM_W-1:0] quo, rem, next_val;
  logic [3:0]                 digit;

  always_comb begin
    hex_mode = (mode_q == itoa_pkg::CMD_HEXB) || (mode_q == itoa_pkg::CMD_HEXW);
    prod     = val_q * itoa_pkg::RECIP_TEN;
    quo      = {3'b0, prod[31:itoa_pkg::RECIP_SH]};
    rem      = val_q - ((quo << 3) + (quo << 1));
    if (hex_mode) begin
      digit    = val_q[3:0];
      next_val = val_q >> 4;
    end else begin
      digit    = rem[3:0];
      next_val = quo;
    end
  end

  always_comb begin
    status_o.no_text = (item_i.cmd > itoa_pkg::CMD_HEXW)
                    || (item_i.cmd == itoa_pkg::CMD_FIXED && item_i.digit_count == '0);
    status_o.signed_mode = (mode_q == itoa_pkg::CMD_SDEC);
    if (mode_q == itoa_pkg::CMD_UDEC || mode_q == itoa_pkg::CMD_SDEC) begin
      status_o.step_final = (next_val == '0);
    end else begin
      status_o.step_final = (left_q == itoa_pkg::CNT_W'(1));
    end
    status_o.pop_final = (fill_q == FW'(1));
  end

  always_comb begin
    val_d  = val_q;
    left_d = left_q;
    if (cmd_i.load) begin
      val_d = in_val;
      case (item_i.cmd)
        itoa_pkg::CMD_FIXED: left_d = in_cnt;
        itoa_pkg::CMD_HEXB:  left_d = itoa_pkg::CNT_W'(2);
        itoa_pkg::CMD_HEXW:  left_d = itoa_pkg::CNT_W'(4);
        default:             left_d = '0;
      endcase
    end else if (cmd_i.step) begin
      val_d  = next_val;
      left_d = left_q - itoa_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    left_q <= left_d;
    if (cmd_i.load) begin
      mode_q <= item_i.cmd;
      neg_q  <= in_neg;
    end
  end

  // character stack: push shifts up, pop shifts down, top at entry 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.step || cmd_i.push_sign) begin
      for (int k = DEPTH - 1; k > 0; k--) begin
        stack_q[k] <= stack_q[k-1];
      end
      if (cmd_i.step) begin
        stack_q[0] <= itoa_pkg::digit_char(digit);
      end else begin
        stack_q[0] <= neg_q ? itoa_pkg::CHAR_MINUS : itoa_pkg::CHAR_SPACE;
      end
    end else if (cmd_i.pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        stack_q[k] <= stack_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.pop;
      if (cmd_i.step || cmd_i.push_sign) begin
        fill_q <= fill_q + FW'(1);
      end else if (cmd_i.pop) begin
        fill_q <= fill_q - FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      result_q.character <= stack_q[0];
      result_q.last      <= (fill_q == FW'(1));
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> fill_q != '0)
    else $error("pop from empty character stack");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || cmd_i.push_sign) |-> fill_q < FW'(DEPTH))
    else $error("push onto full character stack");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && result_q.last) |-> fill_q == '0)
    else $error("last character shown while stack not empty");
`endif

endmodule

// ===== rtl/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl: sequencer of the integer to ASCII formatter
// Steps the datapath through load, digit conversion, sign slot and emission.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  itoa_pkg::dp_status_t status_i,
  output itoa_pkg::dp_cmd_t    cmd_o
);

  itoa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != itoa_pkg::ST_IDLE);
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (start && !status_i.no_text) begin
          cmd_o.load = 1'b1;
          state_d    = itoa_pkg::ST_CONVERT;
        end
      end
      itoa_pkg::ST_CONVERT: begin
        cmd_o.step = 1'b1;
        if (status_i.step_final) begin
          state_d = status_i.signed_mode ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        cmd_o.push_sign = 1'b1;
        state_d         = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        cmd_o.pop = 1'b1;
        if (status_i.pop_final) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.push_sign, cmd_o.pop}))
    else $error("more than one datapath command at once");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == itoa_pkg::ST_CONVERT)
    else $error("load did not start conversion");

  a_sign_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push_sign |=> cmd_o.pop)
    else $error("sign slot not followed by emission");
`endif

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 16-bit integer to ASCII text
// Formats a number as unsigned decimal, signed decimal with sign slot,
// fixed-width zero-padded decimal of the low byte, or two/four hex digits,
// and emits the text one character per strobe, most significant first.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+---------------------------
//   command   | in        | start / busy       | item_i  (cmd, number, digit_count)
//   character | out       | strobe_o, no stall | result_o (character, last)
//
// A transaction is taken when start is high while busy is low. It passes
// through a load, one digit step per digit (1..5 decimal, 1..MAX_WIDTH
// fixed, 2 or 4 hex), a sign slot in signed mode, then one pop per
// character; e.g. a five digit signed value emits six characters.
// The digit loop runs through one shared divide-by-ten unit (a
// reciprocal multiply), one digit per cycle. Each character sits on
// result_o for the single cycle that strobe_o is high; last marks the final
// one. Commands 5..7 and fixed-width with a zero count are taken and produce
// no characters. Reset clears the sequencer and the character count; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int unsigned MAX_WIDTH = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  itoa_pkg::in_t  item_i,
  output logic           strobe_o,
  output itoa_pkg::out_t result_o
);

  // command and status between sequencer and datapath
  itoa_pkg::dp_cmd_t    dp_cmd;
  itoa_pkg::dp_status_t dp_status;

  // sequencer: idle -> convert -> (sign) -> emit
  itoa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  // datapath: working value, digit unit, character stack, output register
  itoa_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (dp_cmd),
    .status_o (dp_status),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

`ifndef NO_ASSERTIONS
  // the final character leaves with the block already free again
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.last) |-> !busy)
    else $error("final character shown while still busy");

  // no character appears unless the block was working on a transaction
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("character strobe without a transaction");

  // an accepted transaction with text keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !dp_status.no_text) |=> busy)
    else $error("accepted transaction did not start");
`endif

endmodule
